/* hdl/rpc_pkg.sv */
package rpc_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [2:0] KIND_NORMAL = 3'd0;
  localparam logic [2:0] KIND_NULL = 3'd1;

  localparam logic [1:0] LINE_VALUE = 2'd1;
  localparam logic [1:0] LINE_SPECIAL = 2'd2;

  localparam int REG_REFLECTANCE_MODE = 0;
  localparam int REG_SOLAR_MULTIPLIER = 1;
  localparam int REG_SOLAR_DISTANCE_SQUARED = 2;

  localparam logic [63:0] SOLAR_MULTIPLIER_RESET = 64'd65536;
  localparam logic [63:0] SOLAR_DISTANCE_SQUARED_RESET = 64'd5347415;

  // pi with 62 fraction bits.
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

  // pi scaled by 2^frac, rounded to nearest.
  function automatic logic [63:0] pi_fixed(input int frac);
    logic [63:0] rounded;
    rounded = PI_Q62 + (64'd1 << (61 - frac));
    return rounded >> (62 - frac);
  endfunction

endpackage

/* hdl/rpc_if.sv */
interface rpc_in_if #(
  parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] raw_value;
  logic [2:0]                   raw_kind;
  logic signed [DATA_WIDTH-1:0] sample_dark;
  logic                         sample_dark_present;
  logic signed [DATA_WIDTH-1:0] line_dark;
  logic [1:0]                   line_dark_kind;
  logic signed [DATA_WIDTH-1:0] flat_value;
  logic                         flat_special;
  logic signed [DATA_WIDTH-1:0] band_gain;
  logic                         band_gain_present;
  logic [DATA_WIDTH-1:0]        solar_value;

  modport source (
    output valid, raw_value, raw_kind, sample_dark, sample_dark_present, line_dark,
           line_dark_kind, flat_value, flat_special, band_gain, band_gain_present,
           solar_value,
    input  ready
  );
  modport sink (
    input  valid, raw_value, raw_kind, sample_dark, sample_dark_present, line_dark,
           line_dark_kind, flat_value, flat_special, band_gain, band_gain_present,
           solar_value,
    output ready
  );
endinterface

interface rpc_out_if #(
  parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] out_value;
  logic [2:0]                   out_kind;

  modport source (output valid, out_value, out_kind, input ready);
  modport sink (input valid, out_value, out_kind, output ready);
endinterface

/* hdl/rpc_pre.sv */
module rpc_pre #(
  parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS = rpc_pkg::FRAC_BITS_DEF,
  parameter int SIDE_W = 5 + 3 * DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [DATA_WIDTH-1:0] raw_value,
  input  logic [2:0]            raw_kind,
  input  logic [DATA_WIDTH-1:0] sample_dark,
  input  logic                  sample_dark_present,
  input  logic [DATA_WIDTH-1:0] line_dark,
  input  logic [1:0]            line_dark_kind,
  input  logic [DATA_WIDTH-1:0] flat_value,
  input  logic                  flat_special,
  input  logic [DATA_WIDTH-1:0] band_gain,
  input  logic                  band_gain_present,
  input  logic [DATA_WIDTH-1:0] solar_value,
  input  logic [DATA_WIDTH-1:0] solar_multiplier,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] num_mag,
  output logic [DATA_WIDTH-1:0] den_mag,
  output logic                  quot_neg,
  output logic                  num_neg,
  output logic [SIDE_W-1:0]     side_out
);

  localparam int W = DATA_WIDTH;

  function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] d;
    d = {a[W-1], a} - {b[W-1], b};
    if (d[W] != d[W-1]) begin
      return d[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    return d[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] a);
    return a[W-1] ? (~a + 1'b1) : a;
  endfunction

  logic                v1;
  logic [2:0]          kind1;
  logic [W-1:0]        x1, ld1, fl1, g1, sv1;
  logic [1:0]          lk1;
  logic                fs1, gp1;

  logic                v2;
  logic [2:0]          kind2;
  logic [W-1:0]        x2, fl2, g2;
  logic                fs2, gp2;
  logic [2*W-1:0]      prod2;

  logic                v3;
  logic [W-1:0]        nm3, fm3, x3, g3, den3;
  logic                qneg3, nneg3, fs3, gp3;
  logic [2:0]          kind3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind1 <= raw_kind;
      x1    <= sample_dark_present ? sat_sub(raw_value, sample_dark) : raw_value;
      ld1   <= line_dark;
      lk1   <= line_dark_kind;
      fl1   <= flat_value;
      fs1   <= flat_special;
      g1    <= band_gain;
      gp1   <= band_gain_present;
      sv1   <= solar_value;

      // A special raw code wins over a special line dark.
      if (kind1 != rpc_pkg::KIND_NORMAL) begin
        kind2 <= kind1;
      end else if (lk1 >= rpc_pkg::LINE_SPECIAL) begin
        kind2 <= rpc_pkg::KIND_NULL;
      end else begin
        kind2 <= rpc_pkg::KIND_NORMAL;
      end
      x2    <= (lk1 == rpc_pkg::LINE_VALUE) ? sat_sub(x1, ld1) : x1;
      fl2   <= fl1;
      fs2   <= fs1;
      g2    <= g1;
      gp2   <= gp1;
      prod2 <= solar_multiplier * sv1;

      nm3   <= mag(x2);
      fm3   <= mag(fl2);
      nneg3 <= x2[W-1];
      qneg3 <= x2[W-1] ^ fl2[W-1];
      kind3 <= kind2;
      x3    <= x2;
      fs3   <= fs2;
      g3    <= g2;
      gp3   <= gp2;
      // The I/F divisor saturates to the unsigned range.
      den3  <= (|prod2[2*W-1:W+FRAC_BITS]) ? {W{1'b1}} : prod2[W+FRAC_BITS-1:FRAC_BITS];
    end
  end

  assign out_valid = v3;
  assign num_mag   = nm3;
  assign den_mag   = fm3;
  assign quot_neg  = qneg3;
  assign num_neg   = nneg3;
  assign side_out  = {kind3, fs3, gp3, x3, g3, den3};

endmodule

/* hdl/rpc_div.sv */
module rpc_div #(
  parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS = rpc_pkg::FRAC_BITS_DEF,
  parameter int SIDE_W = 5 + 3 * DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [DATA_WIDTH-1:0] num_mag,
  input  logic [DATA_WIDTH-1:0] den_mag,
  input  logic                  quot_neg,
  input  logic                  num_neg,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] quot,
  output logic [SIDE_W-1:0]     side_out
);

  localparam int W = DATA_WIDTH;
  localparam int NW = DATA_WIDTH + FRAC_BITS;

  // Each stage holds the numerator bits still to be shifted in at the top of
  // sh and the quotient bits produced so far at its bottom.
  logic [NW-1:0]     sh   [0:NW];
  logic [W-1:0]      rem  [0:NW];
  logic [W-1:0]      dm   [0:NW];
  logic              qn   [0:NW];
  logic              nn   [0:NW];
  logic [SIDE_W-1:0] side [0:NW];
  logic              vld  [0:NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh[0]   <= {num_mag, {FRAC_BITS{1'b0}}};
      rem[0]  <= '0;
      dm[0]   <= den_mag;
      qn[0]   <= quot_neg;
      nn[0]   <= num_neg;
      side[0] <= side_in;
    end
  end

  for (genvar s = 0; s < NW; s++) begin : g_step
    logic [W:0] cand;
    logic [W:0] diff;
    logic       ge;

    assign cand = {rem[s], sh[s][NW-1]};
    assign diff = cand - {1'b0, dm[s]};
    assign ge   = cand >= {1'b0, dm[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sh[s+1]   <= {sh[s][NW-2:0], ge};
        rem[s+1]  <= ge ? diff[W-1:0] : cand[W-1:0];
        dm[s+1]   <= dm[s];
        qn[s+1]   <= qn[s];
        nn[s+1]   <= nn[s];
        side[s+1] <= side[s];
      end
    end
  end

  logic [NW-1:0]     lim;
  logic [W-1:0]      q_next;
  logic              ov;
  logic              vo;
  logic [W-1:0]      qo;
  logic [SIDE_W-1:0] so;

  assign lim = {{(NW-W){1'b0}}, 1'b1, {(W-1){1'b0}}} - {{(NW-1){1'b0}}, ~qn[NW]};
  assign ov  = sh[NW] > lim;

  always_comb begin
    if (dm[NW] == '0) begin
      q_next = nn[NW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else if (ov) begin
      q_next = qn[NW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      q_next = qn[NW] ? (~sh[NW][W-1:0] + 1'b1) : sh[NW][W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= vld[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qo <= q_next;
      so <= side[NW];
    end
  end

  assign out_valid = vo;
  assign quot      = qo;
  assign side_out  = so;

endmodule

/* hdl/rpc_qmul.sv */
module rpc_qmul #(
  parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS = rpc_pkg::FRAC_BITS_DEF,
  parameter int SIDE_W = 5 + 3 * DATA_WIDTH,
  parameter bit B_SIGNED = 1'b1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] prod,
  output logic [SIDE_W-1:0]     side_out
);

  localparam int W = DATA_WIDTH;

  logic              v1, v2, v3;
  logic [W-1:0]      am, bm;
  logic              an, bn, n2;
  logic [2*W-1:0]    p2;
  logic [W-1:0]      p3;
  logic [SIDE_W-1:0] s1, s2, s3;
  logic [W-1:0]      lim;
  logic [W-1:0]      lo;
  logic              b_neg;

  assign b_neg = B_SIGNED & b[W-1];
  assign lim   = n2 ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign lo    = ((|p2[2*W-1:W+FRAC_BITS]) || (p2[W+FRAC_BITS-1:FRAC_BITS] > lim)) ?
                 lim : p2[W+FRAC_BITS-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am <= a[W-1] ? (~a + 1'b1) : a;
      an <= a[W-1];
      bm <= b_neg ? (~b + 1'b1) : b;
      bn <= b_neg;
      s1 <= side_in;
      p2 <= am * bm;
      n2 <= an ^ bn;
      s2 <= s1;
      p3 <= n2 ? (~lo + 1'b1) : lo;
      s3 <= s2;
    end
  end

  assign out_valid = v3;
  assign prod      = p3;
  assign side_out  = s3;

endmodule

/* hdl/radiometric_pixel_calibration.sv */
// Dark and flat-field pixel correction, fully pipelined: one pixel transfer is accepted every
// clock; its result passes through two restoring dividers that retire one quotient bit per stage.
// A two-entry output queue lets input transfers continue while a result waits; the input
// stalls only while that queue is full. Registers are written over APB at byte address
// 4*index (8*index when DATA_WIDTH exceeds 32) and should change only while the block is idle.
module radiometric_pixel_calibration #(
  parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS = rpc_pkg::FRAC_BITS_DEF,
  localparam int PW = (DATA_WIDTH > 32) ? 64 : 32,
  localparam int AW = (DATA_WIDTH > 32) ? 5 : 4
) (
  input  logic          clk,
  input  logic          rst,
  rpc_in_if.sink        in_ch,
  rpc_out_if.source     out_ch,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [PW-1:0] pwdata,
  output logic [PW-1:0] prdata,
  output logic          pready
);

  localparam int W = DATA_WIDTH;
  localparam int SW = 5 + 3 * W;
  localparam int STRIDE = PW / 8;
  localparam logic [AW-1:0] ADDR_REFL = AW'(rpc_pkg::REG_REFLECTANCE_MODE * STRIDE);
  localparam logic [AW-1:0] ADDR_SMUL = AW'(rpc_pkg::REG_SOLAR_MULTIPLIER * STRIDE);
  localparam logic [AW-1:0] ADDR_SDSQ = AW'(rpc_pkg::REG_SOLAR_DISTANCE_SQUARED * STRIDE);
  localparam logic [W-1:0] PI_F = W'(rpc_pkg::pi_fixed(FRAC_BITS));

  // Configuration registers.
  logic         reflectance_mode;
  logic [W-1:0] solar_multiplier;
  logic [W-1:0] solar_distance_squared;
  logic         wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      reflectance_mode       <= 1'b0;
      solar_multiplier       <= W'(rpc_pkg::SOLAR_MULTIPLIER_RESET);
      solar_distance_squared <= W'(rpc_pkg::SOLAR_DISTANCE_SQUARED_RESET);
    end else if (wr) begin
      unique case (paddr)
        ADDR_REFL: reflectance_mode       <= pwdata[0];
        ADDR_SMUL: solar_multiplier       <= pwdata[W-1:0];
        ADDR_SDSQ: solar_distance_squared <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_REFL: prdata = PW'(reflectance_mode);
      ADDR_SMUL: prdata = PW'(solar_multiplier);
      ADDR_SDSQ: prdata = PW'(solar_distance_squared);
      default:   prdata = '0;
    endcase
  end

  // The whole pipeline moves together; the output queue guarantees room.
  logic [1:0] qcount;
  logic       en;

  assign en          = (qcount != 2'd2);
  assign in_ch.ready = en;

  // Side bundle layout: {kind, flat_special, gain_present, x, gain, solar_den}.
  logic          v_pre;
  logic [W-1:0]  nm_pre, fm_pre;
  logic          qn_pre, nn_pre;
  logic [SW-1:0] s_pre;

  rpc_pre #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_W(SW)) u_pre (
    .clk                 (clk),
    .rst                 (rst),
    .en                  (en),
    .in_valid            (in_ch.valid),
    .raw_value           (in_ch.raw_value),
    .raw_kind            (in_ch.raw_kind),
    .sample_dark         (in_ch.sample_dark),
    .sample_dark_present (in_ch.sample_dark_present),
    .line_dark           (in_ch.line_dark),
    .line_dark_kind      (in_ch.line_dark_kind),
    .flat_value          (in_ch.flat_value),
    .flat_special        (in_ch.flat_special),
    .band_gain           (in_ch.band_gain),
    .band_gain_present   (in_ch.band_gain_present),
    .solar_value         (in_ch.solar_value),
    .solar_multiplier    (solar_multiplier),
    .out_valid           (v_pre),
    .num_mag             (nm_pre),
    .den_mag             (fm_pre),
    .quot_neg            (qn_pre),
    .num_neg             (nn_pre),
    .side_out            (s_pre)
  );

  logic          v_d1;
  logic [W-1:0]  q_d1, x_a;
  logic [SW-1:0] s_d1, s_a;

  rpc_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_W(SW)) u_div_flat (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_pre),
    .num_mag   (nm_pre),
    .den_mag   (fm_pre),
    .quot_neg  (qn_pre),
    .num_neg   (nn_pre),
    .side_in   (s_pre),
    .out_valid (v_d1),
    .quot      (q_d1),
    .side_out  (s_d1)
  );

  // A special flat value leaves the pixel undivided.
  assign x_a = s_d1[3*W+1] ? s_d1[3*W-1:2*W] : q_d1;
  assign s_a = {s_d1[SW-1:3*W], x_a, s_d1[2*W-1:0]};

  logic          v_g;
  logic [W-1:0]  p_g, x_b;
  logic [SW-1:0] s_g;

  rpc_qmul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_W(SW), .B_SIGNED(1'b1)) u_mul_gain (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_d1),
    .a         (x_a),
    .b         (s_a[2*W-1:W]),
    .side_in   (s_a),
    .out_valid (v_g),
    .prod      (p_g),
    .side_out  (s_g)
  );

  assign x_b = s_g[3*W] ? p_g : s_g[3*W-1:2*W];

  logic          v_sd;
  logic [W-1:0]  p_sd, xm_sd;
  logic [SW-1:0] s_b, s_sd;

  assign s_b = {s_g[SW-1:3*W], x_b, s_g[2*W-1:0]};

  rpc_qmul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_W(SW), .B_SIGNED(1'b0)) u_mul_dist (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_g),
    .a         (x_b),
    .b         (solar_distance_squared),
    .side_in   (s_b),
    .out_valid (v_sd),
    .prod      (p_sd),
    .side_out  (s_sd)
  );

  assign xm_sd  = p_sd[W-1] ? (~p_sd + 1'b1) : p_sd;

  logic          v_d2;
  logic [W-1:0]  q_d2;
  logic [SW-1:0] s_d2;

  rpc_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_W(SW)) u_div_solar (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_sd),
    .num_mag   (xm_sd),
    .den_mag   (s_sd[W-1:0]),
    .quot_neg  (p_sd[W-1]),
    .num_neg   (p_sd[W-1]),
    .side_in   (s_sd),
    .out_valid (v_d2),
    .quot      (q_d2),
    .side_out  (s_d2)
  );

  logic          v_pi;
  logic [W-1:0]  p_pi, x_e, res_value;
  logic [SW-1:0] s_pi;
  logic [2:0]    res_kind;

  rpc_qmul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_W(SW), .B_SIGNED(1'b0)) u_mul_pi (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_d2),
    .a         (q_d2),
    .b         (PI_F),
    .side_in   (s_d2),
    .out_valid (v_pi),
    .prod      (p_pi),
    .side_out  (s_pi)
  );

  // The I/F path always runs; its result is taken only in reflectance mode.
  assign x_e       = reflectance_mode ? p_pi : s_pi[3*W-1:2*W];
  assign res_kind  = s_pi[SW-1:SW-3];
  assign res_value = (res_kind != rpc_pkg::KIND_NORMAL) ? '0 : x_e;

  // Two-entry output queue.
  logic [W-1:0] q0_value, q1_value;
  logic [2:0]   q0_kind, q1_kind;
  logic         push, pop, push_head;

  assign push      = en & v_pi;
  assign pop       = out_ch.valid & out_ch.ready;
  assign push_head = push & ((qcount == 2'd0) | ((qcount == 2'd1) & pop));

  always_ff @(posedge clk) begin
    if (rst) begin
      qcount <= 2'd0;
    end else begin
      qcount <= qcount + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_head) begin
      q0_value <= res_value;
      q0_kind  <= res_kind;
    end else if (pop) begin
      q0_value <= q1_value;
      q0_kind  <= q1_kind;
    end
    if (push & ~push_head) begin
      q1_value <= res_value;
      q1_kind  <= res_kind;
    end
  end

  assign out_ch.valid     = (qcount != 2'd0);
  assign out_ch.out_value = q0_value;
  assign out_ch.out_kind  = q0_kind;

`ifndef SYNTHESIS
  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (qcount == 2'd2) |-> !in_ch.ready)
    else $error("input accepted while output queue is full");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && qcount == 2'd2))
    else $error("pipeline pushed into a full output queue");

  a_drain_to_empty: assert property (@(posedge clk) disable iff (rst)
    (qcount == 2'd1 && pop && !push) |=> !out_ch.valid)
    else $error("output queue did not empty after last transfer");

  a_special_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.out_kind != rpc_pkg::KIND_NORMAL) |-> (out_ch.out_value == '0))
    else $error("special pixel carries a nonzero value");
`endif

endmodule

/* tb/sv/radiometric_pixel_calibration_test.sv */
`timescale 1ns / 100ps

module radiometric_pixel_calibration_test;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int LATENCY = 2 * (DW + FB) + 17;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [31:0] raw_value;
    logic [2:0]         raw_kind;
    logic signed [31:0] sample_dark;
    logic               sample_dark_present;
    logic signed [31:0] line_dark;
    logic [1:0]         line_dark_kind;
    logic signed [31:0] flat_value;
    logic               flat_special;
    logic signed [31:0] band_gain;
    logic               band_gain_present;
    logic [31:0]        solar_value;
  } pixel_t;

  typedef struct {
    logic [31:0] value;
    logic [2:0]  kind;
  } calibrated_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  rpc_in_if #(.DATA_WIDTH(DW)) in_ch ();
  rpc_out_if #(.DATA_WIDTH(DW)) out_ch ();

  radiometric_pixel_calibration #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pixel_t pixel_queue[$];
  calibrated_t expected_pixels[$];
  int mismatches;
  int cycles;
  bit in_fire;
  bit out_fire;

  // Shadow copies of the calibration registers.
  logic        refl_mode;
  logic [31:0] solar_mult;
  logic [31:0] solar_dist_sq;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Q16.16 arithmetic on exact values, saturated to the signed 32-bit range.
  function automatic longint saturate(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 64'sd2147483647;
    if (v < -128'sd2147483648) return -64'sd2147483648;
    return longint'(v);
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    logic signed [127:0] p, m;
    p = 128'(a) * 128'(b);
    m = (p < 0) ? -p : p;
    m = m >> FB;
    return saturate((p < 0) ? -m : m);
  endfunction

  function automatic longint fx_div(input longint n, input longint d);
    logic signed [127:0] nm, dm, q;
    if (d == 0) return (n < 0) ? -64'sd2147483648 : 64'sd2147483647;
    nm = (n < 0) ? -128'(n) : 128'(n);
    dm = (d < 0) ? -128'(d) : 128'(d);
    q = (nm << FB) / dm;
    return saturate(((n < 0) != (d < 0)) ? -q : q);
  endfunction

  function automatic calibrated_t calibrate(input pixel_t p);
    calibrated_t r;
    longint x, den;
    logic [127:0] prod;
    r.value = '0;
    r.kind = rpc_pkg::KIND_NORMAL;
    if (p.raw_kind != rpc_pkg::KIND_NORMAL) begin
      r.kind = p.raw_kind;
      return r;
    end
    x = p.raw_value;
    if (p.sample_dark_present) x = saturate(128'(x) - 128'(longint'(p.sample_dark)));
    if (p.line_dark_kind >= rpc_pkg::LINE_SPECIAL) begin
      r.kind = rpc_pkg::KIND_NULL;
      return r;
    end
    if (p.line_dark_kind == rpc_pkg::LINE_VALUE)
      x = saturate(128'(x) - 128'(longint'(p.line_dark)));
    if (!p.flat_special) x = fx_div(x, p.flat_value);
    if (p.band_gain_present) x = fx_mul(x, p.band_gain);
    if (refl_mode) begin
      prod = (128'(solar_mult) * 128'(p.solar_value)) >> FB;
      den = (prod > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : longint'(prod);
      x = fx_mul(x, longint'(solar_dist_sq));
      x = fx_div(x, den);
      x = fx_mul(x, longint'(rpc_pkg::pi_fixed(FB)));
    end
    r.value = x[31:0];
    return r;
  endfunction

  // Driver: one pixel per transfer, with a random gap before each.
  int in_gap;
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_gap <= $urandom_range(0, 18);
    end else if (!in_ch.valid || in_fire) begin
      if (in_fire) begin
        void'(pixel_queue.pop_front());
      end
      if (in_gap > 0 || pixel_queue.size() == 0) begin
        if (in_gap > 0) in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid <= 1'b1;
        {in_ch.raw_value, in_ch.raw_kind, in_ch.sample_dark, in_ch.sample_dark_present,
         in_ch.line_dark, in_ch.line_dark_kind, in_ch.flat_value, in_ch.flat_special,
         in_ch.band_gain, in_ch.band_gain_present, in_ch.solar_value} <= pixel_queue[0];
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      end
    end
  end

  // The transfer is sampled at the rising edge and predicted there.
  always @(posedge clk) begin
    pixel_t p;
    in_fire <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      p = '{in_ch.raw_value, in_ch.raw_kind, in_ch.sample_dark, in_ch.sample_dark_present,
            in_ch.line_dark, in_ch.line_dark_kind, in_ch.flat_value, in_ch.flat_special,
            in_ch.band_gain, in_ch.band_gain_present, in_ch.solar_value};
      expected_pixels = {expected_pixels, calibrate(p)};
    end
  end

  int out_stall;
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_stall <= 0;
    end else if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if (out_fire) begin
      out_ch.ready <= 1'b0;
      out_stall <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    calibrated_t e;
    out_fire <= !rst && out_ch.valid && out_ch.ready;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h kind %0d", out_ch.out_value,
                                       out_ch.out_kind);
      end else begin
        e = expected_pixels.pop_front();
        if (out_ch.out_value !== e.value || out_ch.out_kind !== e.kind) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h kind %0d, got %h kind %0d", e.value, e.kind,
                     out_ch.out_value, out_ch.out_kind);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic reg_write(input int index, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(4 * index);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      rpc_pkg::REG_REFLECTANCE_MODE: refl_mode = value[0];
      rpc_pkg::REG_SOLAR_MULTIPLIER: solar_mult = value;
      rpc_pkg::REG_SOLAR_DISTANCE_SQUARED: solar_dist_sq = value;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pixel_queue.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q(input bit tame);
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return tame ? 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh4_0000)
                           : $urandom;
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    bit tame;
    tame = $urandom_range(0, 2) != 0;
    p.raw_value = rand_q(tame);
    p.raw_kind = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(1, 7))
                                             : rpc_pkg::KIND_NORMAL;
    p.sample_dark = rand_q(tame);
    p.sample_dark_present = $urandom;
    p.line_dark = rand_q(tame);
    p.line_dark_kind = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(2, 3))
                                                   : 2'($urandom_range(0, 1));
    p.flat_value = ($urandom_range(0, 9) == 0) ? 32'h0 :
                   (tame ? 32'($urandom_range(32'h4000, 32'h4_0000)) : $urandom);
    if ($urandom & 1) p.flat_value = -p.flat_value;
    p.flat_special = ($urandom_range(0, 4) == 0);
    p.band_gain = tame ? 32'($urandom_range(0, 32'h4_0000)) : $urandom;
    p.band_gain_present = $urandom;
    p.solar_value = tame ? 32'($urandom_range(1, 32'h10_0000)) : $urandom;
    return p;
  endfunction

  initial begin
    pixel_t p;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycles = 0;
    mismatches = 0;
    refl_mode = 1'b0;
    solar_mult = 32'(rpc_pkg::SOLAR_MULTIPLIER_RESET);
    solar_dist_sq = 32'(rpc_pkg::SOLAR_DISTANCE_SQUARED_RESET);
    in_ch.valid = 1'b0;
    {in_ch.raw_value, in_ch.raw_kind, in_ch.sample_dark, in_ch.sample_dark_present,
     in_ch.line_dark, in_ch.line_dark_kind, in_ch.flat_value, in_ch.flat_special,
     in_ch.band_gain, in_ch.band_gain_present, in_ch.solar_value} = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed pixels: pass-through codes, special line dark, zero flat, extremes.
    for (int k = 1; k < 8; k++) begin
      p = random_pixel();
      p.raw_kind = 3'(k);
      pixel_queue = {pixel_queue, p};
    end
    p = '{32'h0001_0000, rpc_pkg::KIND_NORMAL, 32'h0, 1'b0, 32'h0, 2'd2, 32'h1_0000, 1'b0,
          32'h1_0000, 1'b0, 32'h1_0000};
    pixel_queue = {pixel_queue, p};
    p.line_dark_kind = 2'd3;
    pixel_queue = {pixel_queue, p};
    p = '{32'h7FFF_FFFF, rpc_pkg::KIND_NORMAL, 32'h8000_0000, 1'b1, 32'h0, 2'd0, 32'h0, 1'b0,
          32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF};
    pixel_queue = {pixel_queue, p};
    p = '{32'h8000_0000, rpc_pkg::KIND_NORMAL, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 2'd1,
          32'h0, 1'b0, 32'h8000_0000, 1'b1, 32'h0};
    pixel_queue = {pixel_queue, p};
    p = '{32'h0003_8000, rpc_pkg::KIND_NORMAL, 32'h0000_8000, 1'b1, 32'hFFFF_0000, 2'd1,
          32'h8000_0000, 1'b1, 32'h0002_0000, 1'b1, 32'h0001_0000};
    pixel_queue = {pixel_queue, p};
    p = '{32'h0, rpc_pkg::KIND_NORMAL, 32'h0, 1'b0, 32'h0, 2'd0, 32'h1, 1'b0, 32'h1, 1'b1,
          32'h1};
    pixel_queue = {pixel_queue, p};
    for (int k = 0; k < 8; k++) pixel_queue = {pixel_queue, random_pixel()};
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          reg_write(rpc_pkg::REG_REFLECTANCE_MODE, 32'd1);
        end
        1: begin
          reg_write(rpc_pkg::REG_SOLAR_MULTIPLIER, 32'h0);
          reg_write(rpc_pkg::REG_SOLAR_DISTANCE_SQUARED, 32'hFFFF_FFFF);
        end
        2: begin
          reg_write(rpc_pkg::REG_SOLAR_MULTIPLIER, 32'hFFFF_FFFF);
          reg_write(rpc_pkg::REG_SOLAR_DISTANCE_SQUARED, 32'h0);
        end
        3: begin
          reg_write(rpc_pkg::REG_REFLECTANCE_MODE, 32'hFFFF_FFFE);
          reg_write(rpc_pkg::REG_SOLAR_MULTIPLIER, $urandom);
        end
        4: begin
          reg_write(rpc_pkg::REG_REFLECTANCE_MODE, 32'd1);
          reg_write(rpc_pkg::REG_SOLAR_MULTIPLIER, 32'($urandom_range(32'h8000, 32'h4_0000)));
          reg_write(rpc_pkg::REG_SOLAR_DISTANCE_SQUARED, $urandom);
        end
        default: begin
          // Writes past the last register must leave the settings alone.
          reg_write(3, $urandom);
          reg_write(rpc_pkg::REG_SOLAR_MULTIPLIER, 32'(rpc_pkg::SOLAR_MULTIPLIER_RESET));
          reg_write(rpc_pkg::REG_SOLAR_DISTANCE_SQUARED,
                    32'(rpc_pkg::SOLAR_DISTANCE_SQUARED_RESET));
        end
      endcase
      for (int k = 0; k < 100; k++) pixel_queue = {pixel_queue, random_pixel()};
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
